// File: rtl/core/vector_rmse_accumulator_unit_macros.svh
// Assertion macros used by the RMSE accumulator controller RTL.
`ifndef VECTOR_RMSE_ACCUMULATOR_UNIT_MACROS_SVH
`define VECTOR_RMSE_ACCUMULATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VRMSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define VRMSE_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define VRMSE_ASSERT(lbl, prop, msg)
`define VRMSE_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/core/vrmse_pkg.sv
// Shared constants and controller/datapath interface types for the RMSE accumulator.
`timescale 1ns / 1ps
package vrmse_pkg;

  localparam int unsigned LANES      = 4;
  localparam int unsigned LANE_W     = 2;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned SUM_W      = 44;
  localparam int unsigned ROOT_W     = SUM_W / 2;
  localparam int unsigned RMSE_W     = 16;
  localparam int unsigned TOTAL_W    = 11;
  localparam int unsigned DIV_STEP_W = $clog2(SUM_W);
  localparam int unsigned SQ_STEP_W  = $clog2(ROOT_W);

  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);

  typedef logic [LANES-1:0][SAMPLE_W-1:0] sample_vec_t;
  typedef logic [LANES-1:0][RMSE_W-1:0]   rmse_vec_t;

  typedef struct packed {
    logic              accept;
    logic              clear;
    logic              div_start;
    logic              sqrt_start;
    logic              root_we;
    logic              emit;
    logic [LANE_W-1:0] lane;
  } vrmse_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } vrmse_stat_t;

endpackage

// File: rtl/core/vrmse_ctrl.sv
// Sequencing state machine: accumulation, per-lane divide and square root, result strobe.
`timescale 1ns / 1ps
`include "vector_rmse_accumulator_unit_macros.svh"
module vrmse_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic                  last_sample_i,
  output logic                  busy,
  input  vrmse_pkg::vrmse_stat_t stat_i,
  output vrmse_pkg::vrmse_cmd_t  cmd_o
);
  import vrmse_pkg::*;

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_FLUSH = 3'd1;
  localparam logic [2:0] S_DIVGO = 3'd2;
  localparam logic [2:0] S_DIVW  = 3'd3;
  localparam logic [2:0] S_SQGO  = 3'd4;
  localparam logic [2:0] S_SQW   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [LANE_W-1:0] lane_q, lane_d;
  logic              accept;

  assign busy   = (state_q != S_ACC);
  assign accept = start && !busy;

  always_comb begin
    state_d          = state_q;
    lane_d           = lane_q;
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.lane       = lane_q;
    case (state_q)
      S_ACC: begin
        if (accept && last_sample_i) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        lane_d  = '0;
        state_d = S_DIVGO;
      end
      S_DIVGO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVW;
      end
      S_DIVW: begin
        if (stat_i.div_done) state_d = S_SQGO;
      end
      S_SQGO: begin
        cmd_o.sqrt_start = 1'b1;
        state_d          = S_SQW;
      end
      S_SQW: begin
        if (stat_i.sqrt_done) begin
          cmd_o.root_we = 1'b1;
          if (lane_q == LAST_LANE) begin
            state_d = S_OUT;
          end else begin
            lane_d  = lane_q + 1'b1;
            state_d = S_DIVGO;
          end
        end
      end
      S_OUT: begin
        cmd_o.emit  = 1'b1;
        cmd_o.clear = 1'b1;
        state_d     = S_ACC;
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_ACC;
      lane_q  <= '0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
    end
  end

  `VRMSE_ASSERT(a_emit_single, cmd_o.emit |=> !cmd_o.emit, "result strobe held two cycles")
  `VRMSE_ASSERT(a_last_busy, (accept && last_sample_i) |=> busy, "not busy after last sample")
  `VRMSE_ASSERT(a_div_done_wait, stat_i.div_done |-> (state_q == S_DIVW), "divide done unexpected")
  `VRMSE_ASSERT_NEVER(a_sq_done_stray, stat_i.sqrt_done && (state_q != S_SQW),
                      "square root done unexpected")

endmodule

// File: rtl/core/vrmse_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module vrmse_div #(
  parameter int unsigned DIVISOR_W = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [vrmse_pkg::SUM_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]        divisor_i,
  output logic [vrmse_pkg::SUM_W-1:0] quot_o,
  output logic                        done_o
);
  import vrmse_pkg::*;

  logic [SUM_W-1:0]      quo_q;
  logic [DIVISOR_W-1:0]  rem_q, dvs_q;
  logic [DIV_STEP_W-1:0] step_q;
  logic                  run_q, done_q;
  logic [DIVISOR_W:0]    trial, diff;
  logic                  fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= DIV_STEP_W'(SUM_W - 1);
      end else if (run_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[SUM_W-2:0], fits};
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/vrmse_sqrt.sv
// Floor integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module vrmse_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [vrmse_pkg::SUM_W-1:0]  rad_i,
  output logic [vrmse_pkg::ROOT_W-1:0] root_o,
  output logic                         done_o
);
  import vrmse_pkg::*;

  logic [SUM_W-1:0]     rad_q;
  logic [ROOT_W:0]      rem_q;
  logic [ROOT_W-1:0]    root_q;
  logic [SQ_STEP_W-1:0] step_q;
  logic                 run_q, done_q;
  logic [ROOT_W+2:0]    part, trial, diff;
  logic                 fits;

  assign part  = {rem_q, rad_q[SUM_W-1:SUM_W-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign fits  = (part >= trial);
  assign diff  = part - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= SQ_STEP_W'(ROOT_W - 1);
      end else if (run_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
      rem_q  <= fits ? diff[ROOT_W:0] : part[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/vrmse_dpath.sv
// Datapath: residual squaring lanes, saturating sums, sample count and shared divide/root.
`timescale 1ns / 1ps
module vrmse_dpath #(
  parameter int unsigned MAX_SAMPLES = 1024,
  parameter int unsigned CNT_W       = 11
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vrmse_pkg::vrmse_cmd_t          cmd_i,
  output vrmse_pkg::vrmse_stat_t         stat_o,
  input  vrmse_pkg::sample_vec_t         est_i,
  input  vrmse_pkg::sample_vec_t         truth_i,
  output vrmse_pkg::rmse_vec_t           rmse_o,
  output logic [vrmse_pkg::TOTAL_W-1:0]  sample_total_o,
  output logic                           overflow_o
);
  import vrmse_pkg::*;

  logic [CNT_W-1:0]              cnt_q;
  logic                          dropped_q;
  logic                          take;
  logic [LANES-1:0][SQ_W-1:0]    sq_q;
  logic                          sq_vld_q;
  logic [LANES-1:0][SUM_W-1:0]   sum_q;
  logic [LANES-1:0][SAMPLE_W:0]  mag;
  logic [LANES-1:0][SUM_W:0]     sum_add;
  rmse_vec_t                     rmse_q;
  logic [SUM_W-1:0]              quot;
  logic [ROOT_W-1:0]             root;
  logic [CNT_W+TOTAL_W-1:0]      cnt_ext;
  logic                          div_done;
  logic                          sqrt_done;

  assign take = cmd_i.accept && (cnt_q < CNT_W'(MAX_SAMPLES));

  always_comb begin
    for (int c = 0; c < LANES; c++) begin
      logic [SAMPLE_W:0] res;
      res     = {est_i[c][SAMPLE_W-1], est_i[c]} - {truth_i[c][SAMPLE_W-1], truth_i[c]};
      mag[c]  = res[SAMPLE_W] ? (~res + 1'b1) : res;
      sum_add[c] = {1'b0, sum_q[c]} + (SUM_W + 1)'(sq_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < LANES; c++) begin
      sq_q[c] <= mag[c][SAMPLE_W-1:0] * mag[c][SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      dropped_q <= 1'b0;
      sq_vld_q  <= 1'b0;
      sum_q     <= '0;
    end else begin
      sq_vld_q <= take;
      if (cmd_i.clear) begin
        cnt_q     <= '0;
        dropped_q <= 1'b0;
        sum_q     <= '0;
      end else begin
        if (take) cnt_q <= cnt_q + 1'b1;
        if (cmd_i.accept && !take) dropped_q <= 1'b1;
        if (sq_vld_q) begin
          for (int c = 0; c < LANES; c++) begin
            sum_q[c] <= sum_add[c][SUM_W] ? '1 : sum_add[c][SUM_W-1:0];
          end
        end
      end
    end
  end

  vrmse_div #(
    .DIVISOR_W(CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q[cmd_i.lane]),
    .divisor_i  (cnt_q),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  vrmse_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (quot),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  assign stat_o = '{div_done: div_done, sqrt_done: sqrt_done};

  always_ff @(posedge clk_i) begin
    if (cmd_i.root_we) rmse_q[cmd_i.lane] <= root[RMSE_W-1:0];
  end

  assign cnt_ext        = (CNT_W + TOTAL_W)'(cnt_q);
  assign rmse_o         = rmse_q;
  assign sample_total_o = cnt_ext[TOTAL_W-1:0];
  assign overflow_o     = dropped_q;

endmodule

// File: rtl/core/vector_rmse_accumulator_unit.sv
// Top level of the 4-component RMSE accumulator: controller plus datapath.
// Timing: a sample without the last mark is one transfer per cycle, back to back.
// A last-marked sample holds busy high until done_o, which marks the last busy cycle:
// a flush state, then per component a divide start and wait and a root start and wait.
// The receiver cannot stall; a result is valid only in the done_o cycle.
// Reset (async, active low) clears the sums, sample count, overflow flag and controller.
`timescale 1ns / 1ps
module vector_rmse_accumulator_unit #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [vrmse_pkg::SAMPLE_W-1:0] est_0_i,
  input  logic [vrmse_pkg::SAMPLE_W-1:0] est_1_i,
  input  logic [vrmse_pkg::SAMPLE_W-1:0] est_2_i,
  input  logic [vrmse_pkg::SAMPLE_W-1:0] est_3_i,
  input  logic [vrmse_pkg::SAMPLE_W-1:0] truth_0_i,
  input  logic [vrmse_pkg::SAMPLE_W-1:0] truth_1_i,
  input  logic [vrmse_pkg::SAMPLE_W-1:0] truth_2_i,
  input  logic [vrmse_pkg::SAMPLE_W-1:0] truth_3_i,
  input  logic                          last_sample_i,
  output logic                          done_o,
  output logic [vrmse_pkg::RMSE_W-1:0]  rmse_0_o,
  output logic [vrmse_pkg::RMSE_W-1:0]  rmse_1_o,
  output logic [vrmse_pkg::RMSE_W-1:0]  rmse_2_o,
  output logic [vrmse_pkg::RMSE_W-1:0]  rmse_3_o,
  output logic [vrmse_pkg::TOTAL_W-1:0] sample_total_o,
  output logic                          overflow_o
);
  import vrmse_pkg::*;

  // The counter must hold MAX_SAMPLES itself, so one value more than the largest index.
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);

  vrmse_cmd_t  cmd;
  vrmse_stat_t stat;
  sample_vec_t est, truth;
  rmse_vec_t   rmse;

  // Components are packed into lanes so the datapath can treat them uniformly.
  assign est   = {est_3_i, est_2_i, est_1_i, est_0_i};
  assign truth = {truth_3_i, truth_2_i, truth_1_i, truth_0_i};

  // The controller owns the handshake: a transfer happens when start is high and busy
  // is low. After a last-marked sample it walks the four components through the
  // shared divide and root units, then pulses done_o and clears the accumulators.
  vrmse_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .last_sample_i (last_sample_i),
    .busy          (busy),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // The datapath squares the residuals in one stage and adds them to saturating
  // sums in the next; samples beyond capacity only set the overflow flag.
  vrmse_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .est_i          (est),
    .truth_i        (truth),
    .rmse_o         (rmse),
    .sample_total_o (sample_total_o),
    .overflow_o     (overflow_o)
  );

  assign done_o   = cmd.emit;
  assign rmse_0_o = rmse[0];
  assign rmse_1_o = rmse[1];
  assign rmse_2_o = rmse[2];
  assign rmse_3_o = rmse[3];

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the 4-component RMSE accumulator unit.
`timescale 1ns / 1ps
module tb_top;
  import vrmse_pkg::*;

  localparam int unsigned SET_CAPACITY   = 1024;
  localparam int unsigned RANDOM_ITEMS   = 450;
  // A last-marked sample produces its result well within this bound, so the
  // quiet stretch between transfers never comes close to it.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 320;
  localparam logic [SUM_W-1:0] SUM_CEILING = '1;

  typedef struct packed {
    rmse_vec_t          rmse;
    logic [TOTAL_W-1:0] total;
    logic               overflow;
  } rmse_result_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  logic        busy;
  sample_vec_t est_v   = '0;
  sample_vec_t truth_v = '0;
  logic        last_q  = 1'b0;
  logic        done_o;
  logic [RMSE_W-1:0]  rmse_0_o, rmse_1_o, rmse_2_o, rmse_3_o;
  logic [TOTAL_W-1:0] sample_total_o;
  logic               overflow_o;

  // Shadow copy of the accumulator state, advanced on every accepted sample.
  logic [SUM_W-1:0] square_acc [LANES];
  int unsigned      set_count;
  bit               set_dropped;
  rmse_result_t     expected_results [$];
  int unsigned      mismatches = 0;

  always #4 clk_i = ~clk_i;

  vector_rmse_accumulator_unit #(
    .MAX_SAMPLES(SET_CAPACITY)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .est_0_i       (est_v[0]),
    .est_1_i       (est_v[1]),
    .est_2_i       (est_v[2]),
    .est_3_i       (est_v[3]),
    .truth_0_i     (truth_v[0]),
    .truth_1_i     (truth_v[1]),
    .truth_2_i     (truth_v[2]),
    .truth_3_i     (truth_v[3]),
    .last_sample_i (last_q),
    .done_o        (done_o),
    .rmse_0_o      (rmse_0_o),
    .rmse_1_o      (rmse_1_o),
    .rmse_2_o      (rmse_2_o),
    .rmse_3_o      (rmse_3_o),
    .sample_total_o(sample_total_o),
    .overflow_o    (overflow_o)
  );

  function automatic logic [RMSE_W-1:0] floor_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    // The mean square is below 2^44, so the root fits in 22 bits.
    for (int b = 22; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root[RMSE_W-1:0];
  endfunction

  function automatic void clear_set();
    for (int lane = 0; lane < LANES; lane++) square_acc[lane] = '0;
    set_count   = 0;
    set_dropped = 1'b0;
  endfunction

  // Accumulates one sample into the shadow state and, on a last-marked
  // sample, queues the result that the block has to produce.
  function automatic void predict_sample(input sample_vec_t e, input sample_vec_t t,
                                         input logic last);
    longint signed   diff;
    longint unsigned sq;
    longint unsigned acc;
    rmse_result_t    res;
    if (set_count < SET_CAPACITY) begin
      for (int lane = 0; lane < LANES; lane++) begin
        diff = longint'($signed(e[lane])) - longint'($signed(t[lane]));
        sq   = diff * diff;
        acc  = sq + square_acc[lane];
        square_acc[lane] = (acc > SUM_CEILING) ? SUM_CEILING : acc[SUM_W-1:0];
      end
      set_count++;
    end else begin
      // A set that runs past capacity drops the sample but keeps going.
      set_dropped = 1'b1;
    end
    if (last) begin
      for (int lane = 0; lane < LANES; lane++)
        res.rmse[lane] = (set_count == 0) ? '0 : floor_sqrt(square_acc[lane] / set_count);
      res.total    = TOTAL_W'(set_count);
      res.overflow = set_dropped;
      expected_results.insert(expected_results.size(), res);
      clear_set();
    end
  endfunction

  // Presents one sample after an optional random pause and returns at the
  // edge where the transfer happens; start is left high for a back-to-back
  // follower.
  task automatic send_sample(input sample_vec_t e, input sample_vec_t t,
                             input logic last, input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    est_v   <= e;
    truth_v <= t;
    last_q  <= last;
    start   <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_sample(e, t, last);
  endtask

  function automatic logic [SAMPLE_W-1:0] extreme_component();
    case ($urandom_range(0, 4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Half fully random pairs, the rest close pairs (small residuals, where the
  // floor of the root matters) and extreme codes.
  function automatic void draw_sample(output sample_vec_t e, output sample_vec_t t);
    int unsigned mode;
    mode = $urandom_range(0, 9);
    for (int lane = 0; lane < LANES; lane++) begin
      e[lane] = SAMPLE_W'($urandom);
      if (mode < 5) begin
        t[lane] = SAMPLE_W'($urandom);
      end else if (mode < 8) begin
        t[lane] = e[lane] + SAMPLE_W'($urandom_range(0, 64)) - 16'd32;
      end else begin
        e[lane] = extreme_component();
        t[lane] = extreme_component();
      end
    end
  endfunction

  // Single-sample sets at the residual extremes and with no residual.
  task automatic test_single_extremes();
    sample_vec_t e;
    sample_vec_t t;
    send_sample({4{16'h7FFF}}, {4{16'h8000}}, 1'b1, 1'b0);
    send_sample({4{16'h8000}}, {4{16'h7FFF}}, 1'b1, 1'b0);
    e = {16'h1234, 16'hFEDC, 16'h8000, 16'h7FFF};
    send_sample(e, e, 1'b1, 1'b0);
    send_sample({16'h8000, 16'h0001, 16'hFF00, 16'h0100},
                {16'h0000, 16'hFFFF, 16'h0100, 16'h0000}, 1'b1, 1'b1);
    t = {4{16'h0000}};
    send_sample({4{16'hFFFF}}, t, 1'b1, 1'b1);
  endtask

  // Short sets where the floor of both the division and the root shows.
  task automatic test_short_sets();
    send_sample({16'h0003, 16'h0000, 16'h0002, 16'h0001}, '0, 1'b0, 1'b0);
    send_sample({16'h0000, 16'h0005, 16'h0001, 16'h0002}, '0, 1'b1, 1'b0);
    send_sample({4{16'h7FFF}}, {4{16'h8000}}, 1'b0, 1'b1);
    send_sample({16'h0000, 16'h7FFF, 16'h8000, 16'h0001}, '0, 1'b0, 1'b1);
    send_sample({16'h0010, 16'hFFF0, 16'h0000, 16'h8000}, {4{16'h0001}}, 1'b1, 1'b1);
    send_sample('0, {16'h0001, 16'h0002, 16'h0003, 16'h0004}, 1'b0, 1'b0);
    send_sample('0, {16'hFFFF, 16'hFFFE, 16'hFFFD, 16'hFFFC}, 1'b0, 1'b0);
    send_sample('0, '0, 1'b0, 1'b0);
    send_sample({4{16'h0100}}, {4{16'hFF00}}, 1'b1, 1'b0);
  endtask

  // A set that runs past capacity, including a dropped last sample, then a
  // one-sample set to show that the overflow flag was cleared. Lane 0 always
  // carries the largest residual so that the widest sum gets loaded.
  task automatic test_set_too_long();
    sample_vec_t e;
    sample_vec_t t;
    for (int i = 0; i < SET_CAPACITY + 4; i++) begin
      draw_sample(e, t);
      e[0] = 16'h7FFF;
      t[0] = 16'h8000;
      send_sample(e, t, i == SET_CAPACITY + 3, ((i / 100) % 2) == 1);
    end
    draw_sample(e, t);
    send_sample(e, t, 1'b1, 1'b0);
  endtask

  task automatic test_random_sets();
    sample_vec_t e;
    sample_vec_t t;
    int          items_left;
    int unsigned set_len;
    bit          burst;
    items_left = RANDOM_ITEMS;
    while (items_left > 0) begin
      set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      burst   = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < set_len; i++) begin
        draw_sample(e, t);
        send_sample(e, t, i == set_len - 1, burst);
      end
      items_left -= set_len;
    end
  endtask

  // Each done_o cycle carries one result; it is checked against the oldest
  // queued expectation.
  always @(posedge clk_i) begin : result_check
    rmse_result_t want;
    rmse_vec_t    seen;
    if (rst_ni && done_o) begin
      seen = {rmse_3_o, rmse_2_o, rmse_1_o, rmse_0_o};
      if (expected_results.size() == 0) begin
        $error("result with no set pending: total %0d overflow %0b",
               sample_total_o, overflow_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        for (int lane = 0; lane < LANES; lane++) begin
          if (seen[lane] !== want.rmse[lane]) begin
            $error("rmse_%0d: expected %0d, actual %0d", lane, want.rmse[lane], seen[lane]);
            mismatches++;
          end
        end
        if (sample_total_o !== want.total) begin
          $error("sample_total: expected %0d, actual %0d", want.total, sample_total_o);
          mismatches++;
        end
        if (overflow_o !== want.overflow) begin
          $error("overflow: expected %0b, actual %0b", want.overflow, overflow_o);
          mismatches++;
        end
      end
    end
  end

  // Ends the run if neither a sample transfer nor a result shows up for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    clear_set();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_extremes();
    test_short_sets();
    test_set_too_long();
    test_random_sets();

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    // Any stray strobe after the last expected result still gets caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
